// File: src/fm_waveform_oscillator_defines.svh
// ----------------------------------------------------------------------------
// fm waveform oscillator assertion macros
// shared property forms for the port-level checker
// ----------------------------------------------------------------------------
`ifndef FM_WAVEFORM_OSCILLATOR_DEFINES_SVH
`define FM_WAVEFORM_OSCILLATOR_DEFINES_SVH

// same-cycle implication, clocked on clk, off while arst_n is low
`define FMWO_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off while arst_n is low
`define FMWO_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/fmwo_pkg.sv
// ----------------------------------------------------------------------------
// fm waveform oscillator package
// widths, register codes, shared types and the quarter-wave sine table
// ----------------------------------------------------------------------------
`default_nettype none

package fmwo_pkg;

	localparam int COUNT_BITS = 24;
	localparam int SINE_STEPS = 360;
	localparam int LEVEL_BITS = 16;

	localparam int MOD_W   = 16;
	localparam int RATE_W  = 18;
	localparam int BASE_W  = 24;
	localparam int WAVE_W  = 2;
	localparam int DEPTH_W = 17;

	localparam int CFG_DATA_W  = 24;
	localparam int CFG_INDEX_W = 3;

	localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_RATE    = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_BASE_FREQUENCY = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_WAVE_SELECT    = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_MOD_DEPTH      = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_MOD_ENABLE     = 3'd4;

	localparam logic [RATE_W-1:0] RATE_RESET = 18'd48000;
	localparam logic [BASE_W-1:0] BASE_RESET = 24'd5120;

	localparam logic [WAVE_W-1:0] WAVE_SINE     = 2'd0;
	localparam logic [WAVE_W-1:0] WAVE_SQUARE   = 2'd1;
	localparam logic [WAVE_W-1:0] WAVE_SAWTOOTH = 2'd2;
	localparam logic [WAVE_W-1:0] WAVE_TRIANGLE = 2'd3;

	// fm offset: level (q1.15) * depth (q1.16) * 20 has scale 2^-31 hz, base is q16.8
	localparam int FRAC_BITS = 23;
	localparam int PROD_W    = MOD_W + DEPTH_W + 1;
	localparam int SUM_W     = BASE_W + FRAC_BITS + 2;
	localparam int FREQ_W    = BASE_W + 1;

	// period = (rate * 512 + f) / (2 f)
	localparam int RATE_SHIFT = 9;
	localparam int PNUM_W     = RATE_W + RATE_SHIFT + 1;

	// shared divider
	localparam int Q_PER   = PNUM_W - 1;
	localparam int Q_WAVE  = LEVEL_BITS + 1;
	localparam int QUO_W   = Q_PER;
	localparam int NUM_W   = COUNT_BITS + LEVEL_BITS + 2;
	localparam int DEN_W   = FREQ_W + 1;
	localparam int REM_W   = DEN_W + 1;
	localparam int STEP_W  = $clog2(Q_PER + 1);
	localparam int SHIFT_W = $clog2(NUM_W + 1);
	localparam int RAMP_W  = COUNT_BITS + 2;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	localparam int FULL_SCALE = 2 ** (LEVEL_BITS - 1);
	localparam int LVX_W      = LEVEL_BITS + 2;

	// sine table: one quarter wave, entry j is the magnitude at step j
	localparam int QTR_STEPS = SINE_STEPS / 4;
	localparam int QTR_N     = QTR_STEPS + 1;
	localparam int QIDX_W    = $clog2(QTR_N);
	localparam int SIDX_W    = $clog2(SINE_STEPS);

	typedef logic [LEVEL_BITS-1:0] qtr_table_t [QTR_N];

	typedef struct packed {
		logic              start;
		logic [STEP_W-1:0] steps;
		logic [NUM_W-1:0]  num;
		logic [DEN_W-1:0]  den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [QUO_W-1:0] quo;
	} div_rsp_t;

	typedef struct packed {
		logic              held;
		logic [FREQ_W-1:0] freq;
	} freq_res_t;

	// odd taylor series in q2.30, seven terms after x, truncating products
	function automatic qtr_table_t build_quarter();
		qtr_table_t  tbl;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] acc;
		logic [63:0] mag;
		int          j;
		int          k;
		for (j = 0; j < QTR_N; j++) begin
			x    = (64'(4 * j) * 64'd1686629713) / 64'(SINE_STEPS);
			x2   = (x * x) >> 30;
			term = x;
			acc  = x;
			for (k = 1; k <= 7; k++) begin
				term = (term * x2) >> 30;
				term = term / 64'((2 * k) * (2 * k + 1));
				if ((k % 2) == 1) begin
					acc = (acc >= term) ? acc - term : 64'd0;
				end else begin
					acc = acc + term;
				end
			end
			mag    = (acc * 64'(FULL_SCALE) + (64'd1 << 29)) >> 30;
			tbl[j] = mag[LEVEL_BITS-1:0];
		end
		return tbl;
	endfunction

	localparam qtr_table_t QTR_TABLE = build_quarter();

endpackage

`default_nettype wire

// File: src/fmwo_if.sv
// ----------------------------------------------------------------------------
// fm waveform oscillator channels
// valid/ready channels for modulator ticks and output levels
// ----------------------------------------------------------------------------
`default_nettype none

interface fmwo_in_if import fmwo_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [MOD_W-1:0] modulator_level;

	modport source (output valid, output modulator_level, input ready);
	modport sink (input valid, input modulator_level, output ready);
endinterface

interface fmwo_out_if import fmwo_pkg::*; ();
	logic                         valid;
	logic                         ready;
	logic signed [LEVEL_BITS-1:0] level;
	logic                         held;

	modport source (output valid, output level, output held, input ready);
	modport sink (input valid, input level, input held, output ready);
endinterface

`default_nettype wire

// File: src/fmwo_freq.sv
// ----------------------------------------------------------------------------
// fm waveform oscillator effective frequency
// two-stage fm offset multiply and rounded q17.8 frequency with hold detect
// ----------------------------------------------------------------------------
`default_nettype none

module fmwo_freq import fmwo_pkg::*; (
	input  wire logic                    clk,
	input  wire logic signed [MOD_W-1:0] mod_level,
	input  wire logic [BASE_W-1:0]       base_frequency,
	input  wire logic [DEPTH_W-1:0]      mod_depth,
	input  wire logic                    mod_enable,
	output freq_res_t                    res
);

	localparam logic signed [SUM_W-1:0] ROUND_TERM = SUM_W'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [SUM_W-1:0] ONE_TERM   = SUM_W'(1) <<< FRAC_BITS;

	logic signed [PROD_W-1:0] prod_s1;
	logic signed [PROD_W-1:0] product;
	logic signed [SUM_W-1:0]  offset;
	logic signed [SUM_W-1:0]  sum;
	freq_res_t                res_s2;

	assign product = PROD_W'(mod_level) * PROD_W'(signed'({1'b0, mod_depth}));

	// times 20 as 16 + 4
	assign offset = (SUM_W'(prod_s1) <<< 4) + (SUM_W'(prod_s1) <<< 2);
	assign sum    = signed'(SUM_W'(base_frequency) << FRAC_BITS) + ROUND_TERM + offset;

	always_ff @(posedge clk) begin
		prod_s1     <= mod_enable ? product : '0;
		res_s2.held <= (sum < ONE_TERM);
		res_s2.freq <= sum[FRAC_BITS +: FREQ_W];
	end

	assign res = res_s2;

endmodule

`default_nettype wire

// File: src/fmwo_divider.sv
// ----------------------------------------------------------------------------
// fm waveform oscillator divider
// shared radix-2 restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module fmwo_divider import fmwo_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  div_req_t  req,
	output div_rsp_t  rsp
);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [REM_W-1:0]  rem_q;
	logic [NUM_W-1:0]  num_q;
	logic [DEN_W-1:0]  den_q;
	logic [QUO_W-1:0]  quo_q;
	logic [REM_W-1:0]  trial;
	logic [REM_W-1:0]  diff;
	logic              fits;

	assign trial = {rem_q[DEN_W-1:0], num_q[NUM_W-1]};
	assign fits  = (trial >= {1'b0, den_q});
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - STEP_W'(1);
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// upper bits go straight into the remainder, the rest shift in one per cycle
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= REM_W'(req.num >> req.steps);
			num_q <= req.num << (SHIFT_W'(NUM_W) - SHIFT_W'(req.steps));
			den_q <= req.den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? diff : trial;
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			quo_q <= {quo_q[QUO_W-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule

`default_nettype wire

// File: src/fmwo_shaper.sv
// ----------------------------------------------------------------------------
// fm waveform oscillator wave shaper
// maps counter, period and divider quotient to a clamped q1.15 level
// ----------------------------------------------------------------------------
`default_nettype none

module fmwo_shaper import fmwo_pkg::*; (
	input  wire logic [WAVE_W-1:0]        wave_select,
	input  wire logic [Q_WAVE-1:0]        quo,
	input  wire logic [COUNT_BITS-1:0]    count,
	input  wire logic [COUNT_BITS-1:0]    period,
	output logic signed [LEVEL_BITS-1:0]  level
);

	localparam logic signed [LVX_W-1:0] FS_X  = LVX_W'(FULL_SCALE);
	localparam logic signed [LVX_W-1:0] MAX_X = LVX_W'(FULL_SCALE - 1);
	localparam logic signed [LVX_W-1:0] MIN_X = -LVX_W'(FULL_SCALE);

	function automatic logic signed [LEVEL_BITS-1:0] clamp_level(
		input logic signed [LVX_W-1:0] v
	);
		logic signed [LVX_W-1:0] c;
		c = v;
		if (v > MAX_X) begin
			c = MAX_X;
		end else if (v < MIN_X) begin
			c = MIN_X;
		end
		return c[LEVEL_BITS-1:0];
	endfunction

	logic                    first_half;
	logic [SIDX_W-1:0]       idx;
	logic [1:0]              quad;
	logic [SIDX_W-1:0]       m;
	logic [QIDX_W-1:0]       j;
	logic signed [LVX_W-1:0] mag_x;
	logic signed [LVX_W-1:0] quo_x;
	logic signed [LVX_W-1:0] raw;

	assign first_half = ({count, 1'b0} < {1'b0, period});
	assign quo_x      = signed'(LVX_W'(quo));

	always_comb begin
		idx = (quo >= Q_WAVE'(SINE_STEPS)) ? SIDX_W'(SINE_STEPS - 1) : quo[SIDX_W-1:0];
		if (idx >= SIDX_W'(3 * QTR_STEPS)) begin
			quad = 2'd3;
			m    = idx - SIDX_W'(3 * QTR_STEPS);
		end else if (idx >= SIDX_W'(2 * QTR_STEPS)) begin
			quad = 2'd2;
			m    = idx - SIDX_W'(2 * QTR_STEPS);
		end else if (idx >= SIDX_W'(QTR_STEPS)) begin
			quad = 2'd1;
			m    = idx - SIDX_W'(QTR_STEPS);
		end else begin
			quad = 2'd0;
			m    = idx;
		end
		j     = quad[0] ? QIDX_W'(SIDX_W'(QTR_STEPS) - m) : QIDX_W'(m);
		mag_x = signed'(LVX_W'(QTR_TABLE[j]));
	end

	always_comb begin
		case (wave_select)
			WAVE_SINE: begin
				raw = quad[1] ? -mag_x : mag_x;
			end
			WAVE_SQUARE: begin
				raw = first_half ? MAX_X : MIN_X;
			end
			WAVE_SAWTOOTH: begin
				raw = quo_x - FS_X;
			end
			WAVE_TRIANGLE: begin
				raw = first_half ? quo_x - FS_X : FS_X - quo_x;
			end
			default: begin
				raw = '0;
			end
		endcase
		level = clamp_level(raw);
	end

endmodule

`default_nettype wire

// File: src/fm_waveform_oscillator.sv
// ----------------------------------------------------------------------------
// fm waveform oscillator
// counter-based sine/square/sawtooth/triangle oscillator with fm input
// ----------------------------------------------------------------------------
// Each tick item carries the modulator level and returns one output level.
// A tick whose effective frequency is not positive returns the last level with
// held set and leaves the counter alone. A normal tick runs a radix-2 period
// division and, for sine, sawtooth and triangle but not square, a second one
// for the waveform ratio on the same shared divider. Any item waits in the done
// state while the output register is full. Tick is not ready while an item is
// in work; a finished result sits in the output register, so the next tick is
// taken while it waits. Registers must be written only while idle; the block
// itself does not enforce it.
`default_nettype none

module fm_waveform_oscillator import fmwo_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	fmwo_in_if.sink                     tick,
	fmwo_out_if.source                  result,
	input  wire logic                   wr_en,
	input  wire logic [CFG_INDEX_W-1:0] wr_index,
	input  wire logic [CFG_DATA_W-1:0]  wr_data
);

	localparam int ST_W = 4;
	localparam logic [ST_W-1:0] S_IDLE  = 4'd0;
	localparam logic [ST_W-1:0] S_MUL   = 4'd1;
	localparam logic [ST_W-1:0] S_ADD   = 4'd2;
	localparam logic [ST_W-1:0] S_CHECK = 4'd3;
	localparam logic [ST_W-1:0] S_PDIV  = 4'd4;
	localparam logic [ST_W-1:0] S_STEP  = 4'd5;
	localparam logic [ST_W-1:0] S_WAVE  = 4'd6;
	localparam logic [ST_W-1:0] S_WDIV  = 4'd7;
	localparam logic [ST_W-1:0] S_SHAPE = 4'd8;
	localparam logic [ST_W-1:0] S_DONE  = 4'd9;

	logic [RATE_W-1:0]  sample_rate_q;
	logic [BASE_W-1:0]  base_frequency_q;
	logic [WAVE_W-1:0]  wave_select_q;
	logic [DEPTH_W-1:0] mod_depth_q;
	logic               mod_enable_q;

	logic [ST_W-1:0]              state_q;
	logic [COUNT_BITS-1:0]        count_q;
	logic signed [LEVEL_BITS-1:0] last_q;
	logic                         out_valid_q;

	logic signed [MOD_W-1:0]      mod_q;
	logic [COUNT_BITS-1:0]        period_q;
	logic signed [LEVEL_BITS-1:0] res_level_q;
	logic                         res_held_q;
	logic signed [LEVEL_BITS-1:0] out_level_q;
	logic                         out_held_q;

	freq_res_t                    freq_res;
	div_req_t                     div_req;
	div_rsp_t                     div_rsp;
	logic [COUNT_BITS-1:0]        period_next;
	logic [COUNT_BITS:0]          count_inc;
	logic [COUNT_BITS-1:0]        count_next;
	logic [COUNT_BITS:0]          twice_count;
	logic [RAMP_W-1:0]            ramp_n;
	logic signed [LEVEL_BITS-1:0] shape_level;
	logic                         accept;
	logic                         out_load;

	assign tick.ready = (state_q == S_IDLE);
	assign accept     = tick.valid && (state_q == S_IDLE);
	assign out_load   = (state_q == S_DONE) && (!out_valid_q || result.ready);

	assign result.valid = out_valid_q;
	assign result.level = out_level_q;
	assign result.held  = out_held_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_rate_q    <= RATE_RESET;
			base_frequency_q <= BASE_RESET;
			wave_select_q    <= WAVE_SINE;
			mod_depth_q      <= '0;
			mod_enable_q     <= 1'b0;
		end else if (wr_en) begin
			case (wr_index)
				REG_SAMPLE_RATE:    sample_rate_q    <= wr_data[RATE_W-1:0];
				REG_BASE_FREQUENCY: base_frequency_q <= wr_data[BASE_W-1:0];
				REG_WAVE_SELECT:    wave_select_q    <= wr_data[WAVE_W-1:0];
				REG_MOD_DEPTH:      mod_depth_q      <= wr_data[DEPTH_W-1:0];
				REG_MOD_ENABLE:     mod_enable_q     <= wr_data[0];
				default: ;
			endcase
		end
	end

	fmwo_freq u_freq (
		.clk            (clk),
		.mod_level      (mod_q),
		.base_frequency (base_frequency_q),
		.mod_depth      (mod_depth_q),
		.mod_enable     (mod_enable_q),
		.res            (freq_res)
	);

	fmwo_divider u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	fmwo_shaper u_shaper (
		.wave_select (wave_select_q),
		.quo         (div_rsp.quo[Q_WAVE-1:0]),
		.count       (count_q),
		.period      (period_q),
		.level       (shape_level)
	);

	// period clamped to [1, counter max]
	always_comb begin
		if (div_rsp.quo == '0) begin
			period_next = COUNT_BITS'(1);
		end else if (div_rsp.quo > QUO_W'(COUNT_MAX)) begin
			period_next = COUNT_MAX;
		end else begin
			period_next = div_rsp.quo[COUNT_BITS-1:0];
		end
	end

	assign count_inc  = (COUNT_BITS + 1)'(count_q) + (COUNT_BITS + 1)'(1);
	assign count_next = (count_inc >= {1'b0, period_q}) ? '0 : count_inc[COUNT_BITS-1:0];

	// ramp numerator index: 2c for sawtooth, 4c or 2(2c - p) for triangle
	assign twice_count = {count_q, 1'b0};
	always_comb begin
		if (wave_select_q == WAVE_SAWTOOTH) begin
			ramp_n = RAMP_W'(twice_count);
		end else if (twice_count < {1'b0, period_q}) begin
			ramp_n = {count_q, 2'b00};
		end else begin
			ramp_n = RAMP_W'({twice_count - {1'b0, period_q}, 1'b0});
		end
	end

	always_comb begin
		div_req = '0;
		case (state_q)
			S_CHECK: begin
				if (!freq_res.held) begin
					div_req.start = 1'b1;
					div_req.steps = STEP_W'(Q_PER);
					div_req.num   = (NUM_W'(sample_rate_q) << RATE_SHIFT) + NUM_W'(freq_res.freq);
					div_req.den   = {freq_res.freq, 1'b0};
				end
			end
			S_WAVE: begin
				if (wave_select_q != WAVE_SQUARE) begin
					div_req.start = 1'b1;
					div_req.steps = STEP_W'(Q_WAVE);
					if (wave_select_q == WAVE_SINE) begin
						div_req.num = NUM_W'(count_q) * NUM_W'(SINE_STEPS);
						div_req.den = DEN_W'(period_q);
					end else begin
						div_req.num = (NUM_W'(ramp_n) << LEVEL_BITS) + NUM_W'(period_q);
						div_req.den = DEN_W'({period_q, 1'b0});
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			last_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (tick.valid) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_ADD;
				end
				S_ADD: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					state_q <= freq_res.held ? S_DONE : S_PDIV;
				end
				S_PDIV: begin
					if (div_rsp.done) begin
						state_q <= S_STEP;
					end
				end
				S_STEP: begin
					count_q <= count_next;
					state_q <= S_WAVE;
				end
				S_WAVE: begin
					state_q <= (wave_select_q == WAVE_SQUARE) ? S_SHAPE : S_WDIV;
				end
				S_WDIV: begin
					if (div_rsp.done) begin
						state_q <= S_SHAPE;
					end
				end
				S_SHAPE: begin
					last_q  <= shape_level;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mod_q <= tick.modulator_level;
		end
		if (state_q == S_PDIV && div_rsp.done) begin
			period_q <= period_next;
		end
		if (state_q == S_CHECK && freq_res.held) begin
			res_level_q <= last_q;
			res_held_q  <= 1'b1;
		end
		if (state_q == S_SHAPE) begin
			res_level_q <= shape_level;
			res_held_q  <= 1'b0;
		end
		if (out_load) begin
			out_level_q <= res_level_q;
			out_held_q  <= res_held_q;
		end
	end

endmodule

`default_nettype wire

// File: src/fmwo_checker.sv
// ----------------------------------------------------------------------------
// fm waveform oscillator port checker
// port-level properties of the oscillator, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "fm_waveform_oscillator_defines.svh"

module fmwo_checker import fmwo_pkg::*; (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         tick_valid,
	input wire logic                         tick_ready,
	input wire logic                         result_valid,
	input wire logic                         result_ready,
	input wire logic signed [LEVEL_BITS-1:0] result_level,
	input wire logic                         result_held
);

	logic signed [LEVEL_BITS-1:0] last_level_q;

	// last level delivered on the result channel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_level_q <= '0;
		end else if (result_valid && result_ready) begin
			last_level_q <= result_level;
		end
	end

	`FMWO_ASSERT_NXT(a_busy_after_accept, tick_valid && tick_ready, !tick_ready, "tick ready right after an accepted item")
	`FMWO_ASSERT_IMP(a_min_latency, $rose(result_valid), !$past(tick_valid && tick_ready, 1) && !$past(tick_valid && tick_ready, 2), "result appeared too soon after an accept")
	`FMWO_ASSERT_NXT(a_result_stable, result_valid && !result_ready, result_valid && $stable(result_level) && $stable(result_held), "stalled result changed")
	`FMWO_ASSERT_IMP(a_held_repeats, result_valid && result_ready && result_held, result_level == last_level_q, "held item does not repeat the last level")

endmodule

bind fm_waveform_oscillator fmwo_checker u_fmwo_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.tick_valid   (tick.valid),
	.tick_ready   (tick.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.result_level (result.level),
	.result_held  (result.held)
);

`default_nettype wire
